[rtl/interval_platform_count_assert.svh]
// Assertion macros used by the top RTL file of the interval platform counter.
// All checks sample on the rising edge of clk and are off while rst_n is low.
`ifndef INTERVAL_PLATFORM_COUNT_ASSERT_SVH
`define INTERVAL_PLATFORM_COUNT_ASSERT_SVH

// Same-cycle implication.
`define IPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ipc_pkg.sv]
`timescale 1ns / 1ps

package ipc_pkg;

  // Field widths
  localparam int TimeW          = 16;
  localparam int KeyW           = 2 * TimeW;
  localparam int PlatW          = 7;
  localparam int MaxIntervalsDef = 64;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DRAIN
  } ipc_state_t;

  // Control shared by all sorting cells
  typedef struct packed {
    logic ins_en;
    logic shift_en;
  } sort_ctl_t;

  // Interval word travelling down the slot chain
  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] arr;
    logic [TimeW-1:0] dep;
  } tok_t;

endpackage

[rtl/ipc_sort_cell.sv]
`timescale 1ns / 1ps

// One cell of the insertion sorter. Occupied cells hold keys in ascending
// order; a new key lands in the first cell that is empty or whose key is larger, and the
// cells behind it take their front neighbor's key.
module ipc_sort_cell (
  input  logic                     clk,
  input  ipc_pkg::sort_ctl_t       ctl,
  input  logic                     occupied,
  input  logic [ipc_pkg::KeyW-1:0] new_key,
  input  logic [ipc_pkg::KeyW-1:0] prev_key,
  input  logic                     prev_ins,
  input  logic [ipc_pkg::KeyW-1:0] next_key,
  output logic [ipc_pkg::KeyW-1:0] key,
  output logic                     ins
);
  import ipc_pkg::*;

  logic [KeyW-1:0] key_r;
  logic [KeyW-1:0] key_nxt;

  // Insert point: empty cell or a key above the new one
  assign ins = !occupied || (new_key < key_r);
  assign key = key_r;

  // Shift toward the head when unloading, else push back on insert
  always_comb begin
    key_nxt = key_r;
    if (ctl.shift_en) begin
      key_nxt = next_key;
    end else if (ctl.ins_en && ins) begin
      key_nxt = prev_ins ? prev_key : new_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

[rtl/ipc_slot_cell.sv]
`timescale 1ns / 1ps

// One platform slot. A word that reaches an open slot whose end time is
// below its arrival is absorbed; a word reaching the first unopened slot
// opens it; otherwise the word moves on to the next slot.
module ipc_slot_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         opened,
  input  ipc_pkg::tok_t tok_in,
  output ipc_pkg::tok_t tok_out,
  output logic         open_evt
);
  import ipc_pkg::*;

  logic [TimeW-1:0] end_r;
  logic [TimeW-1:0] end_nxt;
  tok_t             tok_r;
  tok_t             tok_nxt;
  logic             fits;

  assign fits     = opened && (end_r < tok_in.arr);
  assign open_evt = tok_in.valid && !opened;
  assign tok_out  = tok_r;

  // Absorb, open or pass the incoming word
  always_comb begin
    end_nxt       = end_r;
    tok_nxt       = tok_in;
    if (tok_in.valid && (fits || !opened)) begin
      end_nxt       = tok_in.dep;
      tok_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    end_r <= end_nxt;
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.arr <= tok_nxt.arr;
    tok_r.dep <= tok_nxt.dep;
  end

endmodule

[rtl/interval_platform_count.sv]
`timescale 1ns / 1ps

// Channel  | Ports                                           | Handshake
// ---------+-------------------------------------------------+-------------------------
// input    | in_arrival_time, in_departure_time, in_last     | start high, busy low
// result   | out_platforms, out_overflow                     | out_valid, one cycle
//
// Loading takes one word per cycle: the sorting chain inserts each key in place.
// After the last word, the sequencer shifts the held intervals into the slot chain,
// lets them walk the slots until none is left, and pulses out_valid once the
// chain is empty, with busy already low.
// Reset is synchronous, active low, and clears counters and the sequencer.
// The receiver cannot stall: out_valid marks each result for one cycle only.
module interval_platform_count #(
  parameter int MAX_INTERVALS = ipc_pkg::MaxIntervalsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ipc_pkg::TimeW-1:0]  in_arrival_time,
  input  logic [ipc_pkg::TimeW-1:0]  in_departure_time,
  input  logic                       in_last,
  output logic                       out_valid,
  output logic [ipc_pkg::PlatW-1:0]  out_platforms,
  output logic                       out_overflow
);
  import ipc_pkg::*;

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  ipc_state_t        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PlatW-1:0]  out_plat_r, out_plat_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  tok_t              head_r, head_nxt;
  sort_ctl_t         ctl;

  logic [KeyW-1:0]   new_key;
  logic [KeyW-1:0]   keys   [MAX_INTERVALS];
  logic              ins_v  [MAX_INTERVALS];
  tok_t              toks   [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] open_vec;
  logic [MAX_INTERVALS-1:0] tok_live;
  logic [CW+PlatW-1:0] used_wide;

  assign new_key   = {in_arrival_time, in_departure_time};
  assign used_wide = {{PlatW{1'b0}}, used_r};

  // Sorting chain
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_sort
    logic [KeyW-1:0] prev_key;
    logic            prev_ins;
    logic [KeyW-1:0] next_key;
    if (i == 0) begin : g_head
      assign prev_key = new_key;
      assign prev_ins = 1'b0;
    end else begin : g_body
      assign prev_key = keys[i-1];
      assign prev_ins = ins_v[i-1];
    end
    if (i == MAX_INTERVALS - 1) begin : g_tail
      assign next_key = keys[i];
    end else begin : g_mid
      assign next_key = keys[i+1];
    end
    ipc_sort_cell u_sort (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (CW'(i) < cnt_r),
      .new_key  (new_key),
      .prev_key (prev_key),
      .prev_ins (prev_ins),
      .next_key (next_key),
      .key      (keys[i]),
      .ins      (ins_v[i])
    );
  end

  // Slot chain
  for (genvar s = 0; s < MAX_INTERVALS; s++) begin : g_slot
    tok_t tok_in;
    if (s == 0) begin : g_first
      assign tok_in = head_r;
    end else begin : g_rest
      assign tok_in = toks[s-1];
    end
    ipc_slot_cell u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .opened   (CW'(s) < used_r),
      .tok_in   (tok_in),
      .tok_out  (toks[s]),
      .open_evt (open_vec[s])
    );
    assign tok_live[s] = toks[s].valid;
  end

  // Sequencer: load, unload into the slot chain, wait for the chain to drain
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r + CW'(|open_vec);
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    out_plat_nxt  = out_plat_r;
    out_ovf_nxt   = out_ovf_r;
    ctl           = '0;
    head_nxt.valid = 1'b0;
    head_nxt.arr   = keys[0][KeyW-1:TimeW];
    head_nxt.dep   = keys[0][TimeW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (cnt_r < CW'(MAX_INTERVALS)) begin
            ctl.ins_en = 1'b1;
            cnt_nxt    = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (cnt_r != '0) begin
          ctl.shift_en   = 1'b1;
          head_nxt.valid = 1'b1;
          cnt_nxt        = cnt_r - CW'(1);
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!head_r.valid && !(|tok_live)) begin
          out_valid_nxt = 1'b1;
          out_plat_nxt  = used_wide[PlatW-1:0];
          out_ovf_nxt   = ovf_r;
          used_nxt      = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      head_r.valid <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      head_r.valid <= head_nxt.valid;
    end
    head_r.arr <= head_nxt.arr;
    head_r.dep <= head_nxt.dep;
    out_plat_r <= out_plat_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_platforms = out_plat_r;
  assign out_overflow  = out_ovf_r;

`include "interval_platform_count_assert.svh"

  `IPC_ASSERT_NOW(a_result_idle, out_valid, !busy, "result while busy")
  `IPC_ASSERT_NEXT(a_load_stays_idle, start && !busy && !in_last, !busy,
                   "left idle on a word without last mark")
  `IPC_ASSERT_NOW(a_used_bound, 1'b1, used_r <= CW'(MAX_INTERVALS),
                  "slot count beyond capacity")
  `IPC_ASSERT_NEXT(a_drain_done, (state_r == ST_DRAIN) && !head_r.valid && !(|tok_live),
                   out_valid, "drained chain gave no result")
  `IPC_ASSERT_NOW(a_one_open, 1'b1, $onehot0(open_vec), "two slots opened at once")

endmodule

[bench/interval_platform_count_tb.sv]
`timescale 1ns / 1ps

module interval_platform_count_tb;
  import ipc_pkg::*;

  localparam int Capacity = MaxIntervalsDef;
  localparam int TotalWords = 700;

  typedef struct packed {
    logic [PlatW-1:0] platforms;
    logic             overflow;
  } count_word_t;

  // Predict platform counts for each interval set and check the block's answers
  class platform_ledger;
    logic [KeyW-1:0] held_keys[$];
    bit              overflow_seen;
    count_word_t     pending_counts[$];
    int              err_count;

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      err_count++;
    endtask

    // Sort by arrival then departure, then first-fit on strictly earlier end times
    function logic [PlatW-1:0] count_platforms();
      logic [KeyW-1:0]  keys[$];
      logic [KeyW-1:0]  key;
      logic [TimeW-1:0] slot_end[$];
      int               j;
      bit               placed;
      keys = held_keys;
      for (int i = 1; i < keys.size(); i++) begin
        key = keys[i];
        j = i;
        while (j > 0 && keys[j-1] > key) begin
          keys[j] = keys[j-1];
          j--;
        end
        keys[j] = key;
      end
      foreach (keys[i]) begin
        placed = 1'b0;
        foreach (slot_end[s]) begin
          if (!placed && slot_end[s] < keys[i][KeyW-1:TimeW]) begin
            slot_end[s] = keys[i][TimeW-1:0];
            placed = 1'b1;
          end
        end
        if (!placed && slot_end.size() < Capacity)
          slot_end.insert(slot_end.size(), keys[i][TimeW-1:0]);
      end
      return PlatW'(slot_end.size());
    endfunction

    // Hold an accepted word; on the last mark, queue the expected count and clear
    function void note_interval(logic [TimeW-1:0] arr, logic [TimeW-1:0] dep, logic last);
      count_word_t w;
      if (held_keys.size() < Capacity) held_keys.insert(held_keys.size(), {arr, dep});
      else overflow_seen = 1'b1;
      if (last) begin
        w.platforms = count_platforms();
        w.overflow  = overflow_seen;
        pending_counts.insert(pending_counts.size(), w);
        held_keys.delete();
        overflow_seen = 1'b0;
      end
    endfunction

    // Compare a result word with the oldest expected count
    task check_count(logic [PlatW-1:0] platforms, logic overflow);
      count_word_t w;
      if (pending_counts.size() == 0) begin
        report($sformatf("result with nothing pending: platforms=%0d overflow=%0b",
                         platforms, overflow));
        return;
      end
      w = pending_counts.pop_front();
      if (platforms !== w.platforms)
        report($sformatf("platforms=%0d, predicted %0d", platforms, w.platforms));
      if (overflow !== w.overflow)
        report($sformatf("overflow=%0b, predicted %0b", overflow, w.overflow));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [TimeW-1:0] in_arrival_time = '0;
  logic [TimeW-1:0] in_departure_time = '0;
  logic             in_last = 1'b0;
  logic             out_valid;
  logic [PlatW-1:0] out_platforms;
  logic             out_overflow;

  platform_ledger ledger = new;
  int             intervals_sent;
  bit             sender_idles;

  interval_platform_count #(
    .MAX_INTERVALS(Capacity)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_arrival_time  (in_arrival_time),
    .in_departure_time(in_departure_time),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_platforms    (out_platforms),
    .out_overflow     (out_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch both channels at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) ledger.check_count(out_platforms, out_overflow);
      if (start && !busy) ledger.note_interval(in_arrival_time, in_departure_time, in_last);
    end
  end

  // Present one word, optionally after an idle gap, and hold it until accepted
  task automatic send_interval(input logic [TimeW-1:0] arr, input logic [TimeW-1:0] dep,
                               input logic last);
    int gap;
    gap = sender_idles ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_arrival_time   <= arr;
    in_departure_time <= dep;
    in_last           <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    intervals_sent++;
  endtask

  // Hold the sender off until every pending count has come back
  task automatic drain_counts();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending_counts.size() != 0) @(posedge clk);
  endtask

  // Send one set of random intervals in one of several shapes
  task automatic send_random_set(input int size);
    int style;
    int base;
    int arr;
    int dep;
    style = $urandom_range(0, 3);
    base  = $urandom_range(0, 16'hFFFF);
    sender_idles = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < size; i++) begin
      case (style)
        0: begin
          // full range, departure may precede arrival
          arr = $urandom_range(0, 16'hFFFF);
          dep = $urandom_range(0, 16'hFFFF);
        end
        1: begin
          // dense grid: many equal and touching times
          arr = $urandom_range(0, 15);
          dep = arr + $urandom_range(0, 4);
        end
        default: begin
          // overlapping cluster near a random base
          arr = base + $urandom_range(0, 60);
          dep = arr + $urandom_range(0, 40);
        end
      endcase
      if (arr > 16'hFFFF) arr = 16'hFFFF;
      if (dep > 16'hFFFF) dep = 16'hFFFF;
      send_interval(TimeW'(arr), TimeW'(dep), i == size - 1);
    end
  endtask

  initial begin
    int set_idx;
    int size;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets: extremes, reversed and touching intervals, duplicates
    sender_idles = 1'b0;
    send_interval(16'h0000, 16'h0000, 1'b1);
    send_interval(16'hFFFF, 16'hFFFF, 1'b1);
    send_interval(16'h0000, 16'hFFFF, 1'b0);
    send_interval(16'hFFFF, 16'h0000, 1'b1);
    sender_idles = 1'b1;
    send_interval(16'd10, 16'd20, 1'b0);
    send_interval(16'd20, 16'd30, 1'b1);
    send_interval(16'd10, 16'd20, 1'b0);
    send_interval(16'd21, 16'd30, 1'b1);
    send_interval(16'd5, 16'd9, 1'b0);
    send_interval(16'd5, 16'd9, 1'b0);
    send_interval(16'd5, 16'd9, 1'b1);
    send_interval(16'd100, 16'd200, 1'b0);
    send_interval(16'd50, 16'd60, 1'b0);
    send_interval(16'd100, 16'd150, 1'b0);
    send_interval(16'd55, 16'd300, 1'b1);
    send_interval(16'h5555, 16'hAAAA, 1'b0);
    send_interval(16'hAAAB, 16'h5555, 1'b1);
    drain_counts();

    // Random sets: mostly small, a few at and past capacity
    set_idx = 0;
    while (intervals_sent < TotalWords) begin
      if (set_idx == 3) size = Capacity;
      else if (set_idx == 7) size = Capacity + 1;
      else if ($urandom_range(0, 11) == 0) size = $urandom_range(Capacity - 4, Capacity + 6);
      else size = $urandom_range(1, 12);
      send_random_set(size);
      if (set_idx % 25 == 10) drain_counts();
      set_idx++;
    end

    // Let the last set finish, then allow the allocation pass to settle
    drain_counts();
    repeat (2 * Capacity + 20) @(posedge clk);
    if (ledger.err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Bound the run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
